// ----- src/pru_pkg.sv -----
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants of the pixel replicate upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

    localparam int COORD_W  = 11;
    localparam int COLOR_W  = 32;
    localparam int ADDR_W   = 24;
    localparam int SCALE_W  = 2;
    localparam int MODE_W   = 2;
    localparam int PITCH_W  = 13;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int CMP_W    = 14;

    localparam int DEF_MAX_WIDTH  = 1920;
    localparam int DEF_MAX_HEIGHT = 1080;
    localparam int DEF_MAX_SCALE  = 3;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REG_OUTPUT_ENABLE = 3'd0;
    localparam logic [2:0] REG_SCALE         = 3'd1;
    localparam logic [2:0] REG_COLOR_MODE    = 3'd2;
    localparam logic [2:0] REG_PHYS_WIDTH    = 3'd3;
    localparam logic [2:0] REG_PHYS_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_PITCH_WORDS   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_PASS        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALPHA = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB565      = 2'd2;

    typedef struct packed {
        logic                output_enable;
        logic [SCALE_W-1:0]  scale;
        logic [MODE_W-1:0]   color_mode;
        logic [COORD_W-1:0]  phys_width;
        logic [COORD_W-1:0]  phys_height;
        logic [PITCH_W-1:0]  pitch_words;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]  px0;
        logic [COORD_W-1:0]  py0;
        logic [COLOR_W-1:0]  color;
        logic [SCALE_W-1:0]  scale;
    } block_t;

endpackage

// ----- src/pru_regs.sv -----
// ----------------------------------------------------------------------------
// pru_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module pru_regs
    import pru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_enable <= 1'b0;
            cfg_reg.scale         <= SCALE_W'(1);
            cfg_reg.color_mode    <= MODE_PASS;
            cfg_reg.phys_width    <= '0;
            cfg_reg.phys_height   <= '0;
            cfg_reg.pitch_words   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_OUTPUT_ENABLE: cfg_reg.output_enable <= pwdata[0];
                REG_SCALE:         cfg_reg.scale         <= pwdata[SCALE_W-1:0];
                REG_COLOR_MODE:    cfg_reg.color_mode    <= pwdata[MODE_W-1:0];
                REG_PHYS_WIDTH:    cfg_reg.phys_width    <= pwdata[COORD_W-1:0];
                REG_PHYS_HEIGHT:   cfg_reg.phys_height   <= pwdata[COORD_W-1:0];
                REG_PITCH_WORDS:   cfg_reg.pitch_words   <= pwdata[PITCH_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_index)
            REG_OUTPUT_ENABLE: prdata = PDATA_W'(cfg_reg.output_enable);
            REG_SCALE:         prdata = PDATA_W'(cfg_reg.scale);
            REG_COLOR_MODE:    prdata = PDATA_W'(cfg_reg.color_mode);
            REG_PHYS_WIDTH:    prdata = PDATA_W'(cfg_reg.phys_width);
            REG_PHYS_HEIGHT:   prdata = PDATA_W'(cfg_reg.phys_height);
            REG_PITCH_WORDS:   prdata = PDATA_W'(cfg_reg.pitch_words);
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- src/pru_front.sv -----
// ----------------------------------------------------------------------------
// pru_front
// Accepts pixel beats, drops those off frame, reduces colour, builds a block.
// ----------------------------------------------------------------------------
module pru_front
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE
)
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] src_x,
    input  logic [COORD_W-1:0] src_y,
    input  logic [COLOR_W-1:0] pixel_color,
    input  cfg_t               cfg,
    input  logic               queue_full,
    output logic               push,
    output block_t             push_block
);

    localparam logic [CMP_W-1:0]     MAX_W_C = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0]     MAX_H_C = CMP_W'(MAX_HEIGHT);
    localparam logic [SCALE_W+1:0]   MAX_S_C = (SCALE_W+2)'(MAX_SCALE);

    logic [SCALE_W-1:0]  s_eff;
    logic [CMP_W-1:0]    w_eff;
    logic [CMP_W-1:0]    h_eff;
    logic [CMP_W-1:0]    x_end;
    logic [CMP_W-1:0]    y_end;
    logic [CMP_W-1:0]    x_base;
    logic [CMP_W-1:0]    y_base;
    logic                in_frame;
    logic [COLOR_W-1:0]  color_red;

    function automatic logic [COLOR_W-1:0] reduce_color(
        input logic [MODE_W-1:0]  mode,
        input logic [COLOR_W-1:0] c
    );
        logic [COLOR_W-1:0] r;
        begin
            case (mode)
                MODE_CLEAR_ALPHA: r = {8'h00, c[23:0]};
                MODE_RGB565:      r = {8'h00, c[23:16] & 8'hF8, c[15:8] & 8'hFC,
                                       c[7:0] & 8'hF8};
                default:          r = c;
            endcase
            return r;
        end
    endfunction

    always_comb
    begin
        if (cfg.scale == '0)
            s_eff = SCALE_W'(1);
        else if ((SCALE_W+2)'(cfg.scale) > MAX_S_C)
            s_eff = MAX_S_C[SCALE_W-1:0];
        else
            s_eff = cfg.scale;

        w_eff = (CMP_W'(cfg.phys_width) > MAX_W_C) ? MAX_W_C : CMP_W'(cfg.phys_width);
        h_eff = (CMP_W'(cfg.phys_height) > MAX_H_C) ? MAX_H_C : CMP_W'(cfg.phys_height);

        x_base = CMP_W'(src_x) * CMP_W'(s_eff);
        y_base = CMP_W'(src_y) * CMP_W'(s_eff);
        x_end  = x_base + CMP_W'(s_eff);
        y_end  = y_base + CMP_W'(s_eff);

        in_frame  = (x_end <= w_eff) && (y_end <= h_eff);
        color_red = reduce_color(cfg.color_mode, pixel_color);
    end

    assign in_stall         = queue_full;
    assign push             = in_valid && !queue_full && cfg.output_enable && in_frame;
    assign push_block.px0   = x_base[COORD_W-1:0];
    assign push_block.py0   = y_base[COORD_W-1:0];
    assign push_block.color = color_red;
    assign push_block.scale = s_eff;

endmodule

// ----- src/pru_queue.sv -----
// ----------------------------------------------------------------------------
// pru_queue
// Short register queue of pixel blocks between front and back.
// ----------------------------------------------------------------------------
module pru_queue
    import pru_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  block_t push_block,
    input  logic   pop,
    output logic   full,
    output logic   head_valid,
    output block_t head_block
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

    block_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_block = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_block;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ----- src/pru_back.sv -----
// ----------------------------------------------------------------------------
// pru_back
// Walks each block dy then dx and drives the registered write beats.
// ----------------------------------------------------------------------------
module pru_back
    import pru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PITCH_W-1:0] pitch_words,
    input  logic               head_valid,
    input  block_t             head_block,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ADDR_W-1:0]  word_address,
    output logic [COLOR_W-1:0] out_color,
    output logic               last_write
);

    logic [SCALE_W-1:0]  dx_reg, dx_next;
    logic [SCALE_W-1:0]  dy_reg, dy_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                last_reg, last_next;
    logic                advance;
    logic                row_end;
    logic                blk_end;
    logic [SCALE_W-1:0]  s_top;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [ADDR_W-1:0]   row_off;

    assign advance = !out_valid_reg || !out_stall;
    assign s_top   = head_block.scale - SCALE_W'(1);
    assign row_end = (dx_reg == s_top);
    assign blk_end = row_end && (dy_reg == s_top);
    assign px      = head_block.px0 + COORD_W'(dx_reg);
    assign py      = head_block.py0 + COORD_W'(dy_reg);
    assign row_off = ADDR_W'(py) * ADDR_W'(pitch_words);
    assign pop     = advance && head_valid && blk_end;

    always_comb
    begin
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                addr_next  = row_off + ADDR_W'(px);
                color_next = head_block.color;
                last_next  = blk_end;
                if (blk_end)
                begin
                    dx_next = '0;
                    dy_next = '0;
                end
                else if (row_end)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + SCALE_W'(1);
                end
                else
                begin
                    dx_next = dx_reg + SCALE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg        <= '0;
            dy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign word_address = addr_reg;
    assign out_color    = color_reg;
    assign last_write   = last_reg;

    // counters stay inside the block
    a_dx_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (dx_reg <= s_top) && (dy_reg <= s_top))
        else $error("replication counter beyond block size");

    // a non-final beat leaves its block queued, so another beat follows
    a_block_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !last_reg |=> out_valid_reg)
        else $error("block ended without a final beat");

    // counters restart after a block leaves the queue
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (dx_reg == '0) && (dy_reg == '0))
        else $error("counters not cleared after block end");

endmodule

// ----- src/pixel_replicate_upscaler.sv -----
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Integer nearest-neighbour upscaler: one pixel in, scale-by-scale writes out.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                payload
//   pixel     in         in_valid / in_stall      src_x, src_y, pixel_color
//   write     out        out_valid / out_stall    word_address, out_color, last_write
//   config    in         psel/penable/pwrite      paddr, pwdata, prdata, pready
//
//   front accepts one pixel beat per cycle; in_stall rises only when the queue is full
//   back emits one write beat per cycle while out_stall is low, scale*scale beats per pixel
//   a pixel beat is registered in the queue, then in the output register; off-frame pixels are dropped
//   reset restores register defaults and empties the queue and output register
//   out_stall holds the output register; the queue lets the front keep going
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] src_x,
    input  logic [COORD_W-1:0] src_y,
    input  logic [COLOR_W-1:0] pixel_color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ADDR_W-1:0]  word_address,
    output logic [COLOR_W-1:0] out_color,
    output logic               last_write
);

    cfg_t   cfg;
    logic   push;
    block_t push_block;
    logic   queue_full;
    logic   pop;
    logic   head_valid;
    block_t head_block;

    pru_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pru_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .src_x       (src_x),
        .src_y       (src_y),
        .pixel_color (pixel_color),
        .cfg         (cfg),
        .queue_full  (queue_full),
        .push        (push),
        .push_block  (push_block)
    );

    pru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_block (push_block),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_block (head_block)
    );

    pru_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pitch_words  (cfg.pitch_words),
        .head_valid   (head_valid),
        .head_block   (head_block),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .word_address (word_address),
        .out_color    (out_color),
        .last_write   (last_write)
    );

endmodule

// ----- tb/tb_pixel_replicate_upscaler.sv -----
// ----------------------------------------------------------------------------
// tb_pixel_replicate_upscaler
// Self-checking bench for the pixel replicate upscaler. Pixels go in through
// the valid/stall channel and each is predicted into its block of replicated
// writes. Every write beat is checked against the oldest predicted write.
// Registers are set over the APB-style port between phases, once the block
// is idle. Directed corner pixels come first, then random phases with mostly
// in-frame pixels, with random gaps or stalls on one or both sides in most phases.
// ----------------------------------------------------------------------------
module tb_pixel_replicate_upscaler;
    import pru_pkg::*;

    localparam logic [MODE_W-1:0] MODE_ALIAS_PASS = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               fin;
    } pix_write_t;

    class replica_writes;
        logic               enable = 1'b0;
        logic [SCALE_W-1:0] scale = 2'd1;
        logic [MODE_W-1:0]  mode = MODE_PASS;
        logic [COORD_W-1:0] width = '0;
        logic [COORD_W-1:0] height = '0;
        logic [PITCH_W-1:0] pitch = '0;
        pix_write_t         due_writes[$];
        int                 errors = 0;

        function void set_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
            case (idx)
                REG_OUTPUT_ENABLE: enable = value[0];
                REG_SCALE:         scale = value[SCALE_W-1:0];
                REG_COLOR_MODE:    mode = value[MODE_W-1:0];
                REG_PHYS_WIDTH:    width = value[COORD_W-1:0];
                REG_PHYS_HEIGHT:   height = value[COORD_W-1:0];
                REG_PITCH_WORDS:   pitch = value[PITCH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_scale();
            int unsigned s;
            s = (scale == 0) ? 1 : scale;
            if (s > DEF_MAX_SCALE)
                s = DEF_MAX_SCALE;
            return s;
        endfunction

        function int unsigned cols();
            return ((width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width) / eff_scale();
        endfunction

        function int unsigned rows();
            return ((height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height) / eff_scale();
        endfunction

        function void note_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 input logic [COLOR_W-1:0] c);
            int unsigned s;
            int unsigned w;
            int unsigned h;
            logic [COLOR_W-1:0] rc;
            pix_write_t wr;
            if (!enable)
                return;
            s = eff_scale();
            w = (width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width;
            h = (height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height;
            if ((32'(x) + 1) * s > w || (32'(y) + 1) * s > h)
                return;
            case (mode)
                MODE_CLEAR_ALPHA: rc = {8'h00, c[23:0]};
                MODE_RGB565:      rc = {8'h00, c[23:19], 3'b000, c[15:10], 2'b00,
                                        c[7:3], 3'b000};
                default:          rc = c;
            endcase
            for (int unsigned dy = 0; dy < s; dy++)
            begin
                for (int unsigned dx = 0; dx < s; dx++)
                begin
                    wr.addr = ADDR_W'((32'(y) * s + dy) * pitch
                                      + 32'(x) * s + dx);
                    wr.color = rc;
                    wr.fin = (dy + 1 == s) && (dx + 1 == s);
                    due_writes.push_back(wr);
                end
            end
        endfunction

        function void check_write(input logic [ADDR_W-1:0] addr,
                                  input logic [COLOR_W-1:0] color, input logic fin);
            pix_write_t wr;
            if (due_writes.size() == 0)
            begin
                $display("%0t unexpected write beat: addr %h color %h last %b",
                         $time, addr, color, fin);
                errors++;
                return;
            end
            wr = due_writes.pop_front();
            if (addr !== wr.addr)
            begin
                $display("%0t word_address: expected %h, got %h", $time, wr.addr, addr);
                errors++;
            end
            if (color !== wr.color)
            begin
                $display("%0t out_color: expected %h, got %h", $time, wr.color, color);
                errors++;
            end
            if (fin !== wr.fin)
            begin
                $display("%0t last_write: expected %b, got %b", $time, wr.fin, fin);
                errors++;
            end
        endfunction

        function int pending();
            return due_writes.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [COORD_W-1:0] src_x = '0;
    logic [COORD_W-1:0] src_y = '0;
    logic [COLOR_W-1:0] pixel_color = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ADDR_W-1:0]  word_address;
    logic [COLOR_W-1:0] out_color;
    logic               last_write;

    replica_writes sb = new();
    bit            send_gaps = 1'b0;
    bit            sink_gaps = 1'b0;
    int            quiet_cycles = 0;

    pixel_replicate_upscaler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_x        (src_x),
        .src_y        (src_y),
        .pixel_color  (pixel_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .word_address (word_address),
        .out_color    (out_color),
        .last_write   (last_write)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // write beat sink with random stalls
    always
    begin : write_sink
        int hold;
        hold = sink_gaps ? $urandom_range(0, 14) : 0;
        if (hold > 0)
        begin
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (out_valid !== 1'b1);
        sb.check_write(word_address, out_color, last_write);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_cfg(input logic en, input logic [SCALE_W-1:0] s,
                           input logic [MODE_W-1:0] m, input logic [COORD_W-1:0] w,
                           input logic [COORD_W-1:0] h, input logic [PITCH_W-1:0] p);
        write_reg(REG_OUTPUT_ENABLE, PDATA_W'(en));
        write_reg(REG_SCALE, PDATA_W'(s));
        write_reg(REG_COLOR_MODE, PDATA_W'(m));
        write_reg(REG_PHYS_WIDTH, PDATA_W'(w));
        write_reg(REG_PHYS_HEIGHT, PDATA_W'(h));
        write_reg(REG_PITCH_WORDS, PDATA_W'(p));
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COLOR_W-1:0] c);
        int gap;
        gap = send_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        src_x <= x;
        src_y <= y;
        pixel_color <= c;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_pixel(x, y, c);
    endtask

    // wait for the block to go idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(input int n, input bit pause_mid);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        for (int i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (sb.pending() > 0);
            end
            if ($urandom_range(0, 9) < 8 && sb.cols() > 0 && sb.rows() > 0)
            begin
                x = COORD_W'($urandom_range(0, sb.cols() - 1));
                y = COORD_W'($urandom_range(0, sb.rows() - 1));
            end
            else
            begin
                x = COORD_W'($urandom_range(0, 2047));
                y = COORD_W'($urandom_range(0, 2047));
            end
            send_pixel(x, y, $urandom);
        end
    endtask

    initial
    begin
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: output disabled
        send_pixel(11'd0, 11'd0, 32'hFFFF_FFFF);
        send_pixel(11'd5, 11'd5, 32'h8040_2010);
        settle();

        // full frame at scale three, 5-6-5
        set_cfg(1'b1, 2'd3, MODE_RGB565, 11'd1920, 11'd1080, 13'd8191);
        send_pixel(11'd0, 11'd0, 32'hFFFF_FFFF);
        send_pixel(11'd639, 11'd359, 32'hA5C3_5A3C);
        send_pixel(11'd640, 11'd0, 32'h1234_5678);
        send_pixel(11'd0, 11'd360, 32'h1234_5678);
        send_pixel(11'd2047, 11'd2047, 32'h0000_0000);
        send_pixel(11'd1919, 11'd1079, 32'hFFFF_FFFF);
        settle();

        // scale zero, oversize frame clamped, zero pitch
        set_cfg(1'b1, 2'd0, MODE_PASS, 11'd2047, 11'd2047, 13'd0);
        send_pixel(11'd1919, 11'd1079, 32'hDEAD_BEEF);
        send_pixel(11'd1920, 11'd0, 32'h0F0F_0F0F);
        send_pixel(11'd0, 11'd1080, 32'hF0F0_F0F0);
        send_pixel(11'd2047, 11'd0, 32'h5555_AAAA);
        settle();

        // tiny frame, alpha cleared
        set_cfg(1'b1, 2'd2, MODE_CLEAR_ALPHA, 11'd7, 11'd5, 13'd100);
        send_pixel(11'd2, 11'd1, 32'hFF80_7F01);
        send_pixel(11'd3, 11'd0, 32'hFF80_7F01);
        send_pixel(11'd0, 11'd2, 32'hFF80_7F01);
        settle();

        // unnamed mode passes through
        set_cfg(1'b1, 2'd1, MODE_ALIAS_PASS, 11'd1, 11'd1, 13'd8191);
        send_pixel(11'd0, 11'd0, 32'hDEAD_BEEF);
        send_pixel(11'd1, 11'd0, 32'hDEAD_BEEF);
        send_pixel(11'd0, 11'd1, 32'hDEAD_BEEF);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            send_gaps = (ph % 4 == 0) || (ph % 4 == 1);
            sink_gaps = (ph % 4 == 0) || (ph % 4 == 2);
            case (ph % 3)
                0:
                begin
                    w = 11'd1920;
                    h = 11'd1080;
                end
                1:
                begin
                    w = COORD_W'($urandom_range(0, 2047));
                    h = COORD_W'($urandom_range(0, 2047));
                end
                default:
                begin
                    w = COORD_W'($urandom_range(1, 64));
                    h = COORD_W'($urandom_range(1, 64));
                end
            endcase
            set_cfg(ph != 5, SCALE_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)),
                    w, h, (ph == 0) ? 13'd8191 : PITCH_W'($urandom_range(0, 8191)));
            send_random(40, ph == 2);
            settle();
        end

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
